// ===== rtl/emv_pkg.sv =====
// package for the multi-turn encoder unwrap and velocity block
// shared widths, reset values, register indexes, controller states and command types
// no dependencies
package emv_pkg;

  // default encoder geometry
  localparam int ENCODER_BITS_DEF = 20;
  localparam int TURN_BITS_DEF    = 12;

  // fixed result widths
  localparam int POS_W = 32;
  localparam int VEL_W = 38;

  // configuration registers
  localparam int RATE_W     = 18;
  localparam int ALPHA_W    = 16;
  localparam int CFG_DATA_W = RATE_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SAMPLE_RATE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FILTER_ALPHA = CFG_IDX_W'(1);

  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(10000);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = '0;

  // filter arithmetic: (old - new) is split into a low unsigned and a high signed part
  localparam int DIFF_W    = VEL_W + 1;
  localparam int DLO_W     = 20;
  localparam int DHI_W     = DIFF_W - DLO_W;
  localparam int PHI_SHIFT = DLO_W - ALPHA_W;
  localparam int MUL_B_W   = RATE_W + 1;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MULV,
    S_DIFF,
    S_MULLO,
    S_MULHI,
    S_SUM,
    S_DONE
  } state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    MUL_VEL,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     in_ready;
    logic     take_sample;
    logic     take_home;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     diff_en;
    logic     lo_en;
    logic     sum_en;
    logic     load_out;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic primed;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== rtl/emv_if.sv =====
// request channel interfaces for the multi-turn encoder block
// sample/home requests in, position and velocity results out; depends on emv_pkg
interface emv_in_if #(
  parameter int ENCODER_BITS = emv_pkg::ENCODER_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [ENCODER_BITS-1:0] raw_position;

  modport source (output valid, output command, output raw_position, input ready);
  modport sink   (input valid, input command, input raw_position, output ready);
endinterface

interface emv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [emv_pkg::POS_W-1:0]   position_counts;
  logic signed [emv_pkg::POS_W-1:0]   angle_from_home;
  logic signed [emv_pkg::VEL_W-1:0]   velocity_raw;
  logic signed [emv_pkg::VEL_W-1:0]   velocity_filtered;

  modport source (output valid, output position_counts, output angle_from_home,
                  output velocity_raw, output velocity_filtered, input ready);
  modport sink   (input valid, input position_counts, input angle_from_home,
                  input velocity_raw, input velocity_filtered, output ready);
endinterface

// ===== rtl/emv_mul.sv =====
// registered signed multiplier shared by the velocity and filter steps
// depends on nothing
module emv_mul #(
  parameter int A_W = 21,
  parameter int B_W = 19
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [A_W-1:0]  a,
  input  logic signed [B_W-1:0]  b,
  output logic signed [A_W+B_W-1:0] p
);

  logic signed [A_W+B_W-1:0] prod_r;
  logic signed [A_W+B_W-1:0] prod_nxt;

  // full precision product
  always_comb begin
    prod_nxt = (A_W+B_W)'(a) * (A_W+B_W)'(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign p = prod_r;

endmodule

// ===== rtl/emv_datapath.sv =====
// datapath: unwrap, turn count, home, config registers, filter arithmetic, result register
// depends on emv_pkg and emv_mul
module emv_datapath #(
  parameter int ENCODER_BITS = emv_pkg::ENCODER_BITS_DEF,
  parameter int TURN_BITS    = emv_pkg::TURN_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  emv_pkg::ctrl_cmd_t                  cmd,
  output emv_pkg::ctrl_sts_t                  sts,
  input  logic [ENCODER_BITS-1:0]             raw_position,
  input  logic                                cfg_wr_en,
  input  logic [emv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [emv_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [emv_pkg::POS_W-1:0]    position_counts,
  output logic signed [emv_pkg::POS_W-1:0]    angle_from_home,
  output logic signed [emv_pkg::VEL_W-1:0]    velocity_raw,
  output logic signed [emv_pkg::VEL_W-1:0]    velocity_filtered
);

  localparam int POS_W     = emv_pkg::POS_W;
  localparam int VEL_W     = emv_pkg::VEL_W;
  localparam int DIFF_W    = emv_pkg::DIFF_W;
  localparam int DLO_W     = emv_pkg::DLO_W;
  localparam int ALPHA_W   = emv_pkg::ALPHA_W;
  localparam int PHI_SHIFT = emv_pkg::PHI_SHIFT;
  localparam int MUL_B_W   = emv_pkg::MUL_B_W;
  localparam int MUL_A_W   = (ENCODER_BITS + 1 > DLO_W + 1) ? ENCODER_BITS + 1 : DLO_W + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic signed [ENCODER_BITS:0] HALF = (ENCODER_BITS+1)'(1) << (ENCODER_BITS - 1);
  localparam logic signed [ENCODER_BITS:0] FULL = (ENCODER_BITS+1)'(1) << ENCODER_BITS;

  // state
  logic [ENCODER_BITS-1:0]          prev_r;
  logic [ENCODER_BITS-1:0]          home_r;
  logic [TURN_BITS-1:0]             turn_r;
  logic                             primed_r;
  logic signed [VEL_W-1:0]          smooth_r;
  logic [emv_pkg::RATE_W-1:0]       rate_r;
  logic [ALPHA_W-1:0]               alpha_r;

  // working registers
  logic signed [ENCODER_BITS:0]     step_r;
  logic signed [DIFF_W-1:0]         diff_r;
  logic [DLO_W-1:0]                 plo_r;
  logic signed [VEL_W-1:0]          vel_raw_r;
  logic signed [VEL_W-1:0]          vel_filt_r;

  // result register
  logic                             out_valid_r;
  logic signed [POS_W-1:0]          pos_out_r;
  logic signed [POS_W-1:0]          rel_out_r;
  logic signed [VEL_W-1:0]          vraw_out_r;
  logic signed [VEL_W-1:0]          vfilt_out_r;

  logic signed [ENCODER_BITS:0]     step_raw;
  logic                             wrap_dn;
  logic                             wrap_up;
  logic signed [ENCODER_BITS:0]     step_nxt;
  logic [TURN_BITS-1:0]             turn_nxt;
  logic signed [MUL_A_W-1:0]        mul_a;
  logic signed [MUL_B_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]         prod;
  logic signed [DIFF_W-1:0]         diff_nxt;
  logic [VEL_W-1:0]                 filt_nxt;
  logic [POS_W-1:0]                 pos_nxt;
  logic [POS_W-1:0]                 rel_nxt;

  // unwrap: a step beyond half a revolution crossed the index
  always_comb begin
    step_raw = $signed({1'b0, raw_position}) - $signed({1'b0, prev_r});
    wrap_dn  = step_raw > HALF;
    wrap_up  = step_raw < -HALF;
    if (wrap_dn) begin
      step_nxt = step_raw - FULL;
      turn_nxt = turn_r - TURN_BITS'(1);
    end else if (wrap_up) begin
      step_nxt = step_raw + FULL;
      turn_nxt = turn_r + TURN_BITS'(1);
    end else begin
      step_nxt = step_raw;
      turn_nxt = turn_r;
    end
  end

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      emv_pkg::MUL_VEL: begin
        mul_a = MUL_A_W'(step_r);
        mul_b = $signed({1'b0, rate_r});
      end
      emv_pkg::MUL_LO: begin
        mul_a = $signed(MUL_A_W'(diff_r[DLO_W-1:0]));
        mul_b = $signed(MUL_B_W'(alpha_r));
      end
      emv_pkg::MUL_HI: begin
        mul_a = MUL_A_W'($signed(diff_r[DIFF_W-1:DLO_W]));
        mul_b = $signed(MUL_B_W'(alpha_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  emv_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_emv_mul (
    .clk (clk),
    .en  (cmd.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // filter: new + floor(((old - new) * alpha) / 2^16), all modulo 2^38
  always_comb begin
    diff_nxt = DIFF_W'(smooth_r) - DIFF_W'($signed(prod[VEL_W-1:0]));
    filt_nxt = VEL_W'(vel_raw_r)
             + {prod[VEL_W-PHI_SHIFT-1:0], {PHI_SHIFT{1'b0}}}
             + VEL_W'(plo_r);
  end

  // multi-turn position and offset from home
  always_comb begin
    pos_nxt = POS_W'(prev_r) + (POS_W'($signed(turn_r)) << ENCODER_BITS);
    rel_nxt = pos_nxt - POS_W'(home_r);
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      home_r      <= '0;
      turn_r      <= '0;
      primed_r    <= 1'b0;
      smooth_r    <= '0;
      rate_r      <= emv_pkg::RATE_RESET;
      alpha_r     <= emv_pkg::ALPHA_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          emv_pkg::CFG_IDX_SAMPLE_RATE:  rate_r  <= cfg_wdata;
          emv_pkg::CFG_IDX_FILTER_ALPHA: alpha_r <= cfg_wdata[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take_home) begin
        turn_r <= '0;
        home_r <= prev_r;
      end
      if (cmd.take_sample) begin
        prev_r   <= raw_position;
        primed_r <= 1'b1;
        if (primed_r) begin
          turn_r <= turn_nxt;
        end
      end
      if (cmd.sum_en) begin
        smooth_r <= $signed(filt_nxt);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      step_r <= step_nxt;
      if (!primed_r) begin
        vel_raw_r  <= '0;
        vel_filt_r <= '0;
      end
    end
    if (cmd.diff_en) begin
      vel_raw_r <= $signed(prod[VEL_W-1:0]);
      diff_r    <= diff_nxt;
    end
    if (cmd.lo_en) begin
      plo_r <= prod[DLO_W+ALPHA_W-1:ALPHA_W];
    end
    if (cmd.sum_en) begin
      vel_filt_r <= $signed(filt_nxt);
    end
    if (cmd.load_out) begin
      pos_out_r   <= $signed(pos_nxt);
      rel_out_r   <= $signed(rel_nxt);
      vraw_out_r  <= vel_raw_r;
      vfilt_out_r <= vel_filt_r;
    end
  end

  assign sts.primed   = primed_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign position_counts   = pos_out_r;
  assign angle_from_home   = rel_out_r;
  assign velocity_raw      = vraw_out_r;
  assign velocity_filtered = vfilt_out_r;

endmodule

// ===== rtl/emv_ctrl.sv =====
// controller: sequences one sample through the shared multiplier and the result register
// depends on emv_pkg
module emv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_command,
  input  emv_pkg::ctrl_sts_t sts,
  output emv_pkg::ctrl_cmd_t cmd
);

  emv_pkg::state_t state_r;
  emv_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= emv_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      emv_pkg::S_IDLE: begin
        if (in_valid && !in_command) begin
          state_nxt = sts.primed ? emv_pkg::S_MULV : emv_pkg::S_DONE;
        end
      end
      emv_pkg::S_MULV:  state_nxt = emv_pkg::S_DIFF;
      emv_pkg::S_DIFF:  state_nxt = emv_pkg::S_MULLO;
      emv_pkg::S_MULLO: state_nxt = emv_pkg::S_MULHI;
      emv_pkg::S_MULHI: state_nxt = emv_pkg::S_SUM;
      emv_pkg::S_SUM:   state_nxt = emv_pkg::S_DONE;
      emv_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_nxt = emv_pkg::S_IDLE;
        end
      end
      default: state_nxt = emv_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.mul_sel = emv_pkg::MUL_VEL;
    case (state_r)
      emv_pkg::S_IDLE: begin
        cmd.in_ready    = 1'b1;
        cmd.take_sample = in_valid && !in_command;
        cmd.take_home   = in_valid && in_command;
      end
      emv_pkg::S_MULV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = emv_pkg::MUL_VEL;
      end
      emv_pkg::S_DIFF: begin
        cmd.diff_en = 1'b1;
      end
      emv_pkg::S_MULLO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = emv_pkg::MUL_LO;
      end
      emv_pkg::S_MULHI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = emv_pkg::MUL_HI;
        cmd.lo_en   = 1'b1;
      end
      emv_pkg::S_SUM: begin
        cmd.sum_en = 1'b1;
      end
      emv_pkg::S_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/encoder_multiturn_velocity_top.sv =====
// Multi-turn absolute encoder unwrap with raw and IIR-filtered velocity. A sample request
// (command 0) is unwrapped against the previous sample, updates the turn count and yields one
// result: multi-turn position, position minus home, step times sample rate and the filtered
// velocity; a home request (command 1) clears the turn count, stores the last sample as home
// and yields no result. A sample occupies the block from accept to the next ready (the first
// sample after reset only primes the state, skips the multiply steps and reports zero
// velocity); the single shared registered multiplier, 21x19 at default widths, is used in turn
// for the velocity and the two halves of the filter product. A finished result
// sits in an output register, so the next request is taken while it waits; a result that is
// not yet taken holds back only the following one. Configuration writes go straight to their
// registers and must be made while the block is idle.
module encoder_multiturn_velocity_top #(
  parameter int ENCODER_BITS = emv_pkg::ENCODER_BITS_DEF,
  parameter int TURN_BITS    = emv_pkg::TURN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  emv_in_if.sink                         in_ch,
  emv_out_if.source                      out_ch,
  input  logic                           cfg_wr_en,
  input  logic [emv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [emv_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  emv_pkg::ctrl_cmd_t cmd;
  emv_pkg::ctrl_sts_t sts;

  // sequencer
  emv_ctrl u_emv_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .sts        (sts),
    .cmd        (cmd)
  );

  // arithmetic and state
  emv_datapath #(
    .ENCODER_BITS (ENCODER_BITS),
    .TURN_BITS    (TURN_BITS)
  ) u_emv_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .raw_position      (in_ch.raw_position),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .position_counts   (out_ch.position_counts),
    .angle_from_home   (out_ch.angle_from_home),
    .velocity_raw      (out_ch.velocity_raw),
    .velocity_filtered (out_ch.velocity_filtered)
  );

  assign in_ch.ready = cmd.in_ready;

endmodule

// ===== rtl/emv_checker.sv =====
// port-level checks for the multi-turn encoder block, bound to the top level
// depends on emv_pkg and encoder_multiturn_velocity_top
module emv_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_command,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [emv_pkg::POS_W-1:0]  position_counts,
  input logic signed [emv_pkg::POS_W-1:0]  angle_from_home,
  input logic signed [emv_pkg::VEL_W-1:0]  velocity_raw,
  input logic signed [emv_pkg::VEL_W-1:0]  velocity_filtered
);

  logic seen_out_r;

  // marks that the first result after reset has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_out_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_out_r <= 1'b1;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(position_counts)
      && $stable(angle_from_home) && $stable(velocity_raw) && $stable(velocity_filtered))
    else $error("result changed while stalled");

  // first result after reset only primes the velocity
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !seen_out_r |-> velocity_raw == '0 && velocity_filtered == '0)
    else $error("first result has nonzero velocity");

  // a sample request occupies the block
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_command |=> !in_ready)
    else $error("request taken while a sample is in work");

  // a home request gives no result
  a_home_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command && !out_valid |=> !out_valid)
    else $error("home request produced a result");

endmodule

bind encoder_multiturn_velocity_top emv_checker u_emv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_command        (in_ch.command),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .position_counts   (out_ch.position_counts),
  .angle_from_home   (out_ch.angle_from_home),
  .velocity_raw      (out_ch.velocity_raw),
  .velocity_filtered (out_ch.velocity_filtered)
);
